### rtl/core/polynomial_horner_evaluator_core_assert.svh
// assertion macros for the polynomial horner evaluator core
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef POLYNOMIAL_HORNER_EVALUATOR_CORE_ASSERT_SVH
`define POLYNOMIAL_HORNER_EVALUATOR_CORE_ASSERT_SVH

// same-cycle implication
`define PHE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PHE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/phe_pkg.sv
// shared types, codes and saturation helpers for the polynomial evaluator
// no dependencies
package phe_pkg;

    localparam int DATA_W    = 32;
    localparam int TERM_W    = 36;
    localparam int DEG_W     = 3;
    localparam int CMD_W     = 2;
    localparam int REG_IDX_W = 3;

    localparam logic [CMD_W-1:0] CMD_VALUE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DERIV  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POWERS = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_DEGREE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_BASE = 3'd1;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ADD,
        ST_EMIT
    } phe_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic add;
    } mac_ctl_t;

    // value does not fit in 32 signed bits
    function automatic logic term_ovf(input logic signed [TERM_W-1:0] v);
        term_ovf = !((&v[TERM_W-1:DATA_W-1]) || !(|v[TERM_W-1:DATA_W-1]));
    endfunction

    function automatic logic signed [DATA_W-1:0] term_clamp(
        input logic signed [TERM_W-1:0] v
    );
        if (term_ovf(v))
        begin
            term_clamp = v[TERM_W-1] ? Q_MIN : Q_MAX;
        end
        else
        begin
            term_clamp = v[DATA_W-1:0];
        end
    endfunction

endpackage

### rtl/core/polynomial_horner_evaluator_core.sv
// polynomial evaluator top level: config registers, sequencer, output register
// depends on phe_pkg, phe_mac and polynomial_horner_evaluator_core_assert.svh
//
// input beat: s_axis_tuser carries the command (value, derivative, powers),
// s_axis_tdata the signed Q16.16 sample x. output beats carry the result and
// its power index in m_axis_tdata, the saturation flag in m_axis_tuser, and
// tlast on the final result of each input beat. a command of 3 is dropped.
// coefficients and degree are written through cfg_we/cfg_index/cfg_data.
// one input beat is worked on at a time; tready is low until its last result
// has been handed to the output register. every Horner step goes through
// the single shared multiplier as a multiply state and then a scale/add/clamp
// state. value takes one step per lower coefficient, derivative one per lower
// coefficient but c0, and powers one step per further power result.
// the next beat is taken in the cycle after the last result is registered.
// a stalled receiver holds the output register and the sequencer waits in
// its emit state. reset clears the degree to zero, every coefficient to 1.0
// and the output register to empty.
`include "polynomial_horner_evaluator_core_assert.svh"

module polynomial_horner_evaluator_core import phe_pkg::*; #(
    parameter int MAX_DEGREE = 6,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // [31:0] x
    input  logic [1:0]           s_axis_tuser,   // [1:0] command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,   // [31:0] result_value, [34:32] term_index
    output logic                 m_axis_tuser,   // [0] saturated
    output logic                 m_axis_tlast,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int CIDX_W = $clog2(MAX_DEGREE + 1);
    localparam logic signed [DATA_W-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    phe_state_t state_reg, state_next;

    logic [DEG_W-1:0]         deg_reg;
    logic signed [DATA_W-1:0] coef_reg [0:MAX_DEGREE];

    logic [CMD_W-1:0]         cmd_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic [DEG_W-1:0]         idx_reg, idx_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg;
    logic [DEG_W-1:0]         out_index_reg;
    logic                     out_last_reg;
    logic                     out_sat_reg;

    logic [DEG_W-1:0]         d_use;
    logic [DEG_W-1:0]         stop_idx;
    logic                     steps_done;
    logic                     is_last;
    logic [DEG_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] coef_rd;
    logic signed [TERM_W-1:0] coef_ext;
    logic signed [TERM_W-1:0] scaled;
    logic signed [TERM_W-1:0] term;
    logic signed [DATA_W-1:0] load_acc;
    logic                     load_sat;
    logic                     in_take;
    logic                     cmd_ok;
    logic                     slot_free;
    logic                     out_load;
    mac_ctl_t                 mac_ctl;
    logic signed [DATA_W-1:0] acc;
    logic                     acc_sat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_reg <= '0;
            for (int i = 0; i <= MAX_DEGREE; i++)
            begin
                coef_reg[i] <= ONE_Q;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DEGREE)
            begin
                deg_reg <= cfg_data[DEG_W-1:0];
            end
            for (int i = 0; i <= MAX_DEGREE; i++)
            begin
                if (cfg_index == REG_COEF_BASE + REG_IDX_W'(i))
                begin
                    coef_reg[i] <= cfg_data;
                end
            end
        end
    end

    always_comb
    begin
        d_use      = (deg_reg > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_reg;
        stop_idx   = (cmd_reg == CMD_DERIV) ? DEG_W'(1) : DEG_W'(0);
        steps_done = (idx_reg <= stop_idx);
        is_last    = (cmd_reg != CMD_POWERS) || (idx_reg == d_use);
        cmd_ok     = (s_axis_tuser == CMD_VALUE) || (s_axis_tuser == CMD_DERIV)
                     || (s_axis_tuser == CMD_POWERS);
        slot_free  = !out_valid_reg || m_axis_tready;
    end

    // one coefficient read port: top coefficient at load, next lower one per step
    always_comb
    begin
        rd_addr = (state_reg == ST_LOAD) ? idx_reg : idx_reg - DEG_W'(1);
        if (rd_addr <= DEG_W'(MAX_DEGREE))
        begin
            coef_rd = coef_reg[rd_addr[CIDX_W-1:0]];
        end
        else
        begin
            coef_rd = '0;
        end
        coef_ext = {{(TERM_W-DATA_W){coef_rd[DATA_W-1]}}, coef_rd};
        // i * c_i by shift-add, i is at most six
        scaled = (rd_addr[0] ? coef_ext : '0)
               + (rd_addr[1] ? (coef_ext <<< 1) : '0)
               + (rd_addr[2] ? (coef_ext <<< 2) : '0);
        case (cmd_reg)
            CMD_VALUE:  term = coef_ext;
            CMD_DERIV:  term = scaled;
            default:    term = '0;
        endcase
        if (cmd_reg == CMD_POWERS)
        begin
            load_acc = ONE_Q;
            load_sat = 1'b0;
        end
        else
        begin
            load_acc = term_clamp(term);
            load_sat = term_ovf(term);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && cmd_ok)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (cmd_reg == CMD_POWERS || steps_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (cmd_reg == CMD_POWERS || steps_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = is_last ? ST_IDLE : ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        mac_ctl       = '0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_LOAD: mac_ctl.load  = 1'b1;
            ST_MUL:  mac_ctl.mul   = 1'b1;
            ST_ADD:  mac_ctl.add   = 1'b1;
            ST_EMIT: out_load      = slot_free;
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign in_take = s_axis_tvalid && s_axis_tready;

    // coefficient index counts down for horner, power index counts up
    always_comb
    begin
        idx_next = idx_reg;
        if (in_take)
        begin
            idx_next = (s_axis_tuser == CMD_POWERS) ? DEG_W'(0) : d_use;
        end
        else if (mac_ctl.mul)
        begin
            idx_next = (cmd_reg == CMD_POWERS) ? idx_reg + DEG_W'(1)
                                               : idx_reg - DEG_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg <= s_axis_tuser;
            x_reg   <= s_axis_tdata;
        end
        if (out_load)
        begin
            out_value_reg <= acc;
            out_index_reg <= (cmd_reg == CMD_POWERS) ? idx_reg : DEG_W'(0);
            out_last_reg  <= is_last;
            out_sat_reg   <= acc_sat;
        end
    end

    phe_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mac_ctl),
        .x        (x_reg),
        .term     (term),
        .load_acc (load_acc),
        .load_sat (load_sat),
        .acc      (acc),
        .sat      (acc_sat)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_index_reg, out_value_reg};
    assign m_axis_tuser  = out_sat_reg;
    assign m_axis_tlast  = out_last_reg;

    `PHE_ASSERT_NEXT(a_mul_then_add, state_reg == ST_MUL, state_reg == ST_ADD,
        "multiply not followed by add")
    `PHE_ASSERT_NOW(a_idx_in_range, state_reg != ST_IDLE, idx_reg <= d_use,
        "term index beyond degree in use")
    `PHE_ASSERT_NEXT(a_drop_bad_cmd, in_take && !cmd_ok, state_reg == ST_IDLE,
        "unknown command started a computation")
    `PHE_ASSERT_NEXT(a_last_frees_input, out_load && is_last, s_axis_tready,
        "input not released after last result")

endmodule

### rtl/core/phe_mac.sv
// shared multiply-accumulate unit: acc <= sat(sat(acc*x >> frac) + term)
// depends on phe_pkg
module phe_mac import phe_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctl_t                 ctl,
    input  logic signed [DATA_W-1:0] x,
    input  logic signed [TERM_W-1:0] term,
    input  logic signed [DATA_W-1:0] load_acc,
    input  logic                     load_sat,
    output logic signed [DATA_W-1:0] acc,
    output logic                     sat
);

    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [TERM_W-1:0]   term_reg;
    logic signed [DATA_W-1:0]   acc_reg, acc_next;
    logic                       sat_reg, sat_next;

    logic signed [2*DATA_W-1:0] shr;
    logic                       m_ovf;
    logic signed [DATA_W-1:0]   m_val;
    logic signed [TERM_W-1:0]   sum;

    // arithmetic shift is floor rounding
    always_comb
    begin
        shr   = prod_reg >>> FRAC_BITS;
        m_ovf = !((&shr[2*DATA_W-1:DATA_W-1]) || !(|shr[2*DATA_W-1:DATA_W-1]));
        if (m_ovf)
        begin
            m_val = shr[2*DATA_W-1] ? Q_MIN : Q_MAX;
        end
        else
        begin
            m_val = shr[DATA_W-1:0];
        end
        sum = {{(TERM_W-DATA_W){m_val[DATA_W-1]}}, m_val} + term_reg;
    end

    always_comb
    begin
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (ctl.load)
        begin
            acc_next = load_acc;
            sat_next = load_sat;
        end
        else if (ctl.add)
        begin
            acc_next = term_clamp(sum);
            sat_next = sat_reg | m_ovf | term_ovf(sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            prod_reg <= acc_reg * x;
            term_reg <= term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            sat_reg <= sat_next;
        end
    end

    assign acc = acc_reg;
    assign sat = sat_reg;

endmodule

### tb/horner_result_checker.sv
// result checker for the polynomial horner evaluator: shadows the config registers,
// predicts every output beat from each accepted input beat and compares them in order
// depends on phe_pkg
module horner_result_checker import phe_pkg::*; #(
    parameter int MAX_DEGREE = 6,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // [31:0] x
    input  logic [1:0]           s_axis_tuser,   // [1:0] command
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [39:0]          m_axis_tdata,   // [31:0] result_value, [34:32] term_index
    input  logic                 m_axis_tuser,   // [0] saturated
    input  logic                 m_axis_tlast,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output int                   mismatch_count,
    output int                   awaited_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_COEF    = 7;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [DEG_W-1:0]         term;
        logic                     last;
        logic                     sat;
    } poly_result_t;

    logic [DEG_W-1:0]         degree_shadow;
    logic signed [DATA_W-1:0] coef_shadow [NUM_COEF];
    poly_result_t             awaited_results [$];

    function automatic logic signed [DATA_W-1:0] clamp_q(input longint v, inout logic hit);
        if (v > longint'(Q_MAX))
        begin
            hit = 1'b1;
            return Q_MAX;
        end
        if (v < longint'(Q_MIN))
        begin
            hit = 1'b1;
            return Q_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    // exact 64-bit product, floor shift, then clamp
    function automatic logic signed [DATA_W-1:0] fixed_mul(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        inout logic                     hit
    );
        longint prod;
        prod = longint'(a) * longint'(b);
        return clamp_q(prod >>> FRAC_BITS, hit);
    endfunction

    task automatic predict_results(
        input logic [CMD_W-1:0]         cmd,
        input logic signed [DATA_W-1:0] x
    );
        int                       d;
        int                       i;
        logic                     hit;
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] prod;
        poly_result_t             r;
        d   = (degree_shadow > MAX_DEGREE) ? MAX_DEGREE : int'(degree_shadow);
        hit = 1'b0;
        case (cmd)
            CMD_VALUE:
            begin
                acc = coef_shadow[d];
                for (i = d - 1; i >= 0; i--)
                begin
                    prod = fixed_mul(acc, x, hit);
                    acc  = clamp_q(longint'(prod) + longint'(coef_shadow[i]), hit);
                end
                r = '{value: acc, term: '0, last: 1'b1, sat: hit};
                awaited_results.push_back(r);
            end
            CMD_DERIV:
            begin
                // degree zero gives a flat zero with no saturation
                acc = '0;
                if (d > 0)
                begin
                    acc = clamp_q(longint'(d) * longint'(coef_shadow[d]), hit);
                    for (i = d - 1; i >= 1; i--)
                    begin
                        prod = fixed_mul(acc, x, hit);
                        acc  = clamp_q(longint'(prod) + longint'(i) * longint'(coef_shadow[i]),
                                       hit);
                    end
                end
                r = '{value: acc, term: '0, last: 1'b1, sat: hit};
                awaited_results.push_back(r);
            end
            CMD_POWERS:
            begin
                acc = 1 << FRAC_BITS;
                for (i = 0; i <= d; i++)
                begin
                    if (i > 0)
                    begin
                        acc = fixed_mul(acc, x, hit);
                    end
                    r = '{value: acc, term: DEG_W'(i), last: (i == d), sat: hit};
                    awaited_results.push_back(r);
                end
            end
            default:
            begin
                // unused command: dropped without a result
            end
        endcase
    endtask

    task automatic flag_error(input string detail);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t ns: %s", $time, detail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        poly_result_t got;
        poly_result_t want;
        int           k;
        if (!rst_n)
        begin
            degree_shadow = '0;
            for (k = 0; k < NUM_COEF; k++)
            begin
                coef_shadow[k] = 1 << FRAC_BITS;
            end
            awaited_results.delete();
            mismatch_count = 0;
            awaited_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DEGREE)
                begin
                    degree_shadow = cfg_data[DEG_W-1:0];
                end
                else
                begin
                    coef_shadow[cfg_index - REG_COEF_BASE] = cfg_data;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_results(s_axis_tuser, s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value = m_axis_tdata[DATA_W-1:0];
                got.term  = m_axis_tdata[DATA_W+DEG_W-1:DATA_W];
                got.last  = m_axis_tlast;
                got.sat   = m_axis_tuser;
                if (awaited_results.size() == 0)
                begin
                    flag_error($sformatf("unexpected beat: value %h term %0d last %b sat %b",
                                         got.value, got.term, got.last, got.sat));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.value !== want.value || got.term !== want.term ||
                        got.last !== want.last || got.sat !== want.sat)
                    begin
                        flag_error($sformatf({"mismatch: expected value %h term %0d last %b ",
                                              "sat %b, got value %h term %0d last %b sat %b"},
                                             want.value, want.term, want.last, want.sat,
                                             got.value, got.term, got.last, got.sat));
                    end
                end
            end
            awaited_count <= awaited_results.size();
        end
    end

endmodule

### tb/polynomial_horner_evaluator_core_tb.sv
// testbench top for the polynomial horner evaluator core: clock, reset, register
// writes and input beats with random gaps and output stalls, verdict at the end
// depends on phe_pkg, polynomial_horner_evaluator_core and horner_result_checker
module polynomial_horner_evaluator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import phe_pkg::*;

    localparam int MAX_DEGREE        = 6;
    localparam int FRAC_BITS         = 16;
    localparam int NUM_COEF          = 7;
    localparam int SETTLE_CYCLES     = 24;   // longest beat latency plus margin
    localparam int NUM_RANDOM_PHASES = 8;
    localparam int BEATS_PER_PHASE   = 25;

    localparam logic [CMD_W-1:0]         CMD_NONE = 2'd3;   // no meaning, dropped
    localparam logic signed [DATA_W-1:0] Q_ONE    = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_HALF   = 32'sh0000_8000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;   // [31:0] x
    logic [1:0]           s_axis_tuser;   // [1:0] command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [39:0]          m_axis_tdata;   // [31:0] result_value, [34:32] term_index
    logic                 m_axis_tuser;   // [0] saturated
    logic                 m_axis_tlast;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    int mismatch_count;
    int awaited_count;
    int gap_pct   = 9;
    int stall_pct = 75;

    logic signed [DATA_W-1:0] coef_set [NUM_COEF];

    polynomial_horner_evaluator_core #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    horner_result_checker #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // mostly small magnitudes so that not every polynomial saturates
    function automatic logic [DATA_W-1:0] pick_q();
        logic [DATA_W-1:0] mag;
        case ($urandom_range(9, 0))
            0, 1:
            begin
                return $urandom;
            end
            2:
            begin
                case ($urandom_range(6, 0))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return Q_ONE;
                    4:       return -Q_ONE;
                    5:       return 32'd1;
                    default: return '1;
                endcase
            end
            default:
            begin
                mag = $urandom_range(32'h0002_0000, 0);
                return $urandom_range(1, 0) ? -mag : mag;
            end
        endcase
    endfunction

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] x);
        while ($urandom_range(99, 0) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= x;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // degree word carries random upper bits, only the low three count
    task automatic program_poly(input logic [DEG_W-1:0] deg);
        logic [DATA_W-1:0] word;
        int                k;
        word             = $urandom;
        word[DEG_W-1:0]  = deg;
        write_reg(REG_DEGREE, word);
        for (k = 0; k < NUM_COEF; k++)
        begin
            write_reg(REG_IDX_W'(REG_COEF_BASE + k), coef_set[k]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending, let every awaited beat arrive and the core go quiet
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic signed [DATA_W-1:0] probe_x [5];
        logic [DEG_W-1:0]         phase_degree [NUM_RANDOM_PHASES];
        logic [CMD_W-1:0]         cmd;
        int                       p;
        int                       n;
        int                       k;
        int                       r;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_VALUE;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_DEGREE;
        cfg_data      <= '0;
        probe_x       = '{Q_MAX, Q_MIN, '0, -Q_ONE, Q_HALF};
        phase_degree  = '{3'd0, 3'd6, 3'd7, 3'd3, 3'd1, 3'd5, 3'd2, 3'd4};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: degree zero, every coefficient 1.0
        send_beat(CMD_VALUE, '0);
        send_beat(CMD_DERIV, Q_ONE);
        send_beat(CMD_POWERS, Q_MIN);
        send_beat(CMD_NONE, Q_MAX);
        drain();

        // degree seven falls back to six, coefficients at the extremes
        coef_set = '{Q_MAX, Q_MIN, Q_ONE, -Q_ONE, '0, 32'sh0002_8000, -Q_HALF};
        program_poly(3'd7);
        for (k = 0; k < 5; k++)
        begin
            send_beat(CMD_VALUE, probe_x[k]);
            send_beat(CMD_DERIV, probe_x[k]);
            send_beat(CMD_POWERS, probe_x[k]);
        end
        send_beat(CMD_NONE, Q_ONE);
        drain();

        // degree one: derivative is just the linear coefficient
        for (k = 0; k < NUM_COEF; k++)
        begin
            coef_set[k] = pick_q();
        end
        program_poly(3'd1);
        send_beat(CMD_DERIV, Q_ONE);
        send_beat(CMD_VALUE, pick_q());
        send_beat(CMD_POWERS, pick_q());
        drain();

        for (p = 0; p < NUM_RANDOM_PHASES; p++)
        begin
            if (p == 2)
            begin
                gap_pct   = 75;
                stall_pct = 9;
            end
            if (p == 5)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            for (k = 0; k < NUM_COEF; k++)
            begin
                coef_set[k] = pick_q();
            end
            program_poly(phase_degree[p]);
            for (n = 0; n < BEATS_PER_PHASE; n++)
            begin
                r   = $urandom_range(19, 0);
                cmd = (r < 6) ? CMD_VALUE : (r < 12) ? CMD_DERIV :
                      (r < 18) ? CMD_POWERS : CMD_NONE;
                send_beat(cmd, pick_q());
            end
            drain();
        end

        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin : watchdog
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
